### hw/rtl/ftvr_pkg.sv
// ----------------------------------------------------------------------------
// ftvr_pkg: shared codes and constants for the fan triangulation remap unit
// Action codes, configuration register indexes, field widths and the epoch
// encoding used to tag entries of the vertex map.
// ----------------------------------------------------------------------------
package ftvr_pkg;

  // Field widths fixed by the word format
  localparam int ACT_W      = 2;
  localparam int MAT_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Default map depth
  localparam int VERTEX_MAX_DEF = 4096;

  // Material numbers at or above this never match
  localparam int MAT_MAX = 256;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_FACE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SKIN = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PASS = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MATERIAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_MATERIALS  = 1'd1;

  // Pass epoch tags; an entry tagged EPOCH_NONE is never in use
  localparam int               EPOCH_W     = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 4'd0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'd15;

  // Corner position within a face
  localparam logic [1:0] CP_FIRST  = 2'd0;
  localparam logic [1:0] CP_SECOND = 2'd1;
  localparam logic [1:0] CP_LATER  = 2'd2;

endpackage

### hw/rtl/fan_triangulate_vertex_remap_unit.sv
// ----------------------------------------------------------------------------
// fan_triangulate_vertex_remap_unit: dense vertex remap with fan triangulation
// Corners stream in face by face; each accepted corner gets a dense index on
// first use in a pass, and fan triangles are emitted in mapped indices.
// ----------------------------------------------------------------------------
// An accepted word moves from stage 1 to the output register when it advances.
// Throughput: one word per cycle unless the sweep, an epoch wrap or out_stall
//   holds the input; limited by the single map memory port pair (one read,
//   one write each cycle) with one-deep write forwarding.
// Reset: synchronous, active low. After reset, and after every 15th new-pass
//   word, a clearing sweep rewrites all VERTEX_MAX entries, one entry a cycle;
//   in_stall stays high while it runs. Configuration writes are always taken.
module fan_triangulate_vertex_remap_unit
  import ftvr_pkg::*;
#(
  parameter int VERTEX_MAX = VERTEX_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  // Configuration write port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,

  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ACT_W-1:0]              in_action,
  input  logic [$clog2(VERTEX_MAX)-1:0] in_vertex_index,
  input  logic                          in_last_of_face,
  input  logic [MAT_W-1:0]              in_face_material,

  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [$clog2(VERTEX_MAX)-1:0] out_mapped_index,
  output logic                          out_present,
  output logic                          out_first_use,
  output logic                          out_tri_valid,
  output logic [$clog2(VERTEX_MAX)-1:0] out_tri_a,
  output logic [$clog2(VERTEX_MAX)-1:0] out_tri_b,
  output logic [$clog2(VERTEX_MAX)-1:0] out_tri_c,
  output logic [$clog2(VERTEX_MAX):0]   out_vertex_total
);

  localparam int IDX_W = $clog2(VERTEX_MAX);
  localparam int CNT_W = IDX_W + 1;
  localparam int ENT_W = EPOCH_W + IDX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MAT_W-1:0] match_material_r;
  logic             all_materials_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_material_r <= '0;
      all_materials_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATCH_MATERIAL: match_material_r <= cfg_data[MAT_W-1:0];
        CFG_ALL_MATERIALS:  all_materials_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Map memory. Each entry holds {epoch tag, dense index}. An entry is in use
  // in the current pass only when its tag equals the current epoch, so a new
  // pass clears every used mark just by advancing the epoch. When the epoch
  // wraps, a sweep rewrites every tag to EPOCH_NONE so stale tags cannot alias.
  // --------------------------------------------------------------------------
  logic [ENT_W-1:0] map_mem [VERTEX_MAX];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  // Pass and sweep state
  logic [EPOCH_W-1:0] epoch_r;
  logic [EPOCH_W-1:0] epoch_nxt;
  logic               sweep_r;
  logic [IDX_W-1:0]   sweep_cnt_r;
  logic               sweep_start;
  logic               sweep_done;

  // Stage 1: the word whose map entry is being read
  logic             s1_valid_r;
  logic [ACT_W-1:0] s1_action_r;
  logic [IDX_W-1:0] s1_addr_r;
  logic             s1_last_r;
  logic [MAT_W-1:0] s1_mat_r;
  logic             s1_adv;
  logic             s1_wrap;

  // Last item write, forwarded to the next read of the same entry
  logic             wr_valid_r;
  logic [IDX_W-1:0] wr_addr_r;
  logic [ENT_W-1:0] wr_data_r;

  // Fan and counter state
  logic [CNT_W-1:0] next_idx_r;
  logic [CNT_W-1:0] next_idx_nxt;
  logic [1:0]       corner_r;
  logic [1:0]       corner_nxt;
  logic [IDX_W-1:0] fan_first_r;
  logic [IDX_W-1:0] fan_first_nxt;
  logic [IDX_W-1:0] fan_prev_r;
  logic [IDX_W-1:0] fan_prev_nxt;

  // Output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_mapped_r;
  logic             out_present_r;
  logic             out_first_use_r;
  logic             out_tri_valid_r;
  logic [IDX_W-1:0] out_tri_a_r;
  logic [IDX_W-1:0] out_tri_b_r;
  logic [IDX_W-1:0] out_tri_c_r;
  logic [CNT_W-1:0] out_total_r;

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  logic             in_accept;
  logic [IDX_W-1:0] in_addr;

  // A new-pass word that wraps the epoch must not let the next word read
  // the map before the sweep has run; hold the input for that cycle too.
  assign s1_wrap  = s1_valid_r && (s1_action_r == ACT_PASS) && (epoch_r == EPOCH_LAST);
  assign s1_adv   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = sweep_r || (s1_valid_r && !s1_adv) || s1_wrap;
  assign in_accept = in_valid && !in_stall;

  // Fold an out-of-range index back into the map; one subtract suffices
  // because the port can hold less than twice the depth.
  assign in_addr = (CNT_W'(in_vertex_index) >= CNT_W'(VERTEX_MAX)) ?
                   IDX_W'(CNT_W'(in_vertex_index) - CNT_W'(VERTEX_MAX)) :
                   in_vertex_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_addr_r   <= in_addr;
      s1_last_r   <= in_last_of_face;
      s1_mat_r    <= in_face_material;
    end
  end

  // Memory: read on accept, registered data; one write port
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data_r <= map_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 processing
  // --------------------------------------------------------------------------
  logic [ENT_W-1:0]   ent;
  logic [EPOCH_W-1:0] ent_tag;
  logic [IDX_W-1:0]   ent_idx;
  logic               used;
  logic               face_ok;
  logic [IDX_W-1:0]   m_idx;
  logic               item_we;
  logic [ENT_W-1:0]   item_wdata;

  logic [IDX_W-1:0]   res_mapped;
  logic               res_present;
  logic               res_first_use;
  logic               res_tri_valid;
  logic [IDX_W-1:0]   res_tri_a;
  logic [IDX_W-1:0]   res_tri_b;
  logic [IDX_W-1:0]   res_tri_c;

  // The word behind a writer read the entry at the very edge it was written
  assign ent     = (wr_valid_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : rd_data_r;
  assign ent_tag = ent[ENT_W-1:IDX_W];
  assign ent_idx = ent[IDX_W-1:0];
  assign used    = (ent_tag == epoch_r);
  assign face_ok = all_materials_r ||
                   ((32'(s1_mat_r) < MAT_MAX) && (s1_mat_r == match_material_r));
  assign m_idx   = used ? ent_idx : next_idx_r[IDX_W-1:0];

  always_comb begin
    res_mapped    = '0;
    res_present   = 1'b0;
    res_first_use = 1'b0;
    res_tri_valid = 1'b0;
    res_tri_a     = '0;
    res_tri_b     = '0;
    res_tri_c     = '0;
    item_we       = 1'b0;
    item_wdata    = {epoch_r, next_idx_r[IDX_W-1:0]};
    epoch_nxt     = epoch_r;
    sweep_start   = 1'b0;
    next_idx_nxt  = next_idx_r;
    corner_nxt    = corner_r;
    fan_first_nxt = fan_first_r;
    fan_prev_nxt  = fan_prev_r;

    unique case (s1_action_r)
      ACT_PASS: begin
        // Advance the epoch; on wrap, restart at the first tag and sweep
        if (epoch_r == EPOCH_LAST) begin
          epoch_nxt   = EPOCH_FIRST;
          sweep_start = 1'b1;
        end else begin
          epoch_nxt = epoch_r + EPOCH_W'(1);
        end
        next_idx_nxt  = '0;
        corner_nxt    = CP_FIRST;
        fan_first_nxt = '0;
        fan_prev_nxt  = '0;
      end

      ACT_SKIN: begin
        if (used) begin
          res_mapped  = ent_idx;
          res_present = 1'b1;
        end
      end

      ACT_FACE: begin
        if (face_ok) begin
          if (!used) begin
            item_we       = 1'b1;
            next_idx_nxt  = next_idx_r + CNT_W'(1);
            res_first_use = 1'b1;
          end
          res_mapped  = m_idx;
          res_present = 1'b1;

          case (corner_r)
            CP_FIRST: begin
              fan_first_nxt = m_idx;
              fan_prev_nxt  = m_idx;
              if (s1_last_r) begin
                // Single-corner face: degenerate triangle on itself
                res_tri_valid = 1'b1;
                res_tri_a     = m_idx;
                res_tri_b     = m_idx;
                res_tri_c     = m_idx;
              end
            end
            CP_SECOND: begin
              if (s1_last_r) begin
                // Two-corner face closes back on its first corner
                res_tri_valid = 1'b1;
                res_tri_a     = fan_first_r;
                res_tri_b     = m_idx;
                res_tri_c     = fan_first_r;
              end
              fan_prev_nxt = m_idx;
            end
            default: begin
              res_tri_valid = 1'b1;
              res_tri_a     = fan_first_r;
              res_tri_b     = fan_prev_r;
              res_tri_c     = m_idx;
              fan_prev_nxt  = m_idx;
            end
          endcase

          if (s1_last_r) begin
            corner_nxt = CP_FIRST;
          end else if (corner_r == CP_FIRST) begin
            corner_nxt = CP_SECOND;
          end else begin
            corner_nxt = CP_LATER;
          end
        end else if (s1_last_r) begin
          // Rejected last corner still closes the face
          corner_nxt = CP_FIRST;
        end
      end

      default: ;
    endcase
  end

  // Memory write mux: the sweep owns the port while it runs
  assign mem_we    = sweep_r || (s1_adv && item_we);
  assign mem_waddr = sweep_r ? sweep_cnt_r : s1_addr_r;
  assign mem_wdata = sweep_r ? {EPOCH_NONE, {IDX_W{1'b0}}} : item_wdata;

  assign sweep_done = (sweep_cnt_r == IDX_W'(VERTEX_MAX - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= EPOCH_FIRST;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      next_idx_r  <= '0;
      corner_r    <= CP_FIRST;
      fan_first_r <= '0;
      fan_prev_r  <= '0;
      wr_valid_r  <= 1'b0;
    end else begin
      if (sweep_r) begin
        sweep_cnt_r <= sweep_cnt_r + IDX_W'(1);
        if (sweep_done) begin
          sweep_r <= 1'b0;
        end
        wr_valid_r <= 1'b0;
      end else if (s1_adv) begin
        epoch_r     <= epoch_nxt;
        next_idx_r  <= next_idx_nxt;
        corner_r    <= corner_nxt;
        fan_first_r <= fan_first_nxt;
        fan_prev_r  <= fan_prev_nxt;
        if (sweep_start) begin
          sweep_r     <= 1'b1;
          sweep_cnt_r <= '0;
        end
        if (item_we) begin
          wr_valid_r <= 1'b1;
        end
      end
    end
  end

  // Forwarding payload: keep the latest item write
  always_ff @(posedge clk) begin
    if (!sweep_r && s1_adv && item_we) begin
      wr_addr_r <= s1_addr_r;
      wr_data_r <= item_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: load when stage 1 advances, drop when taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mapped_r    <= res_mapped;
      out_present_r   <= res_present;
      out_first_use_r <= res_first_use;
      out_tri_valid_r <= res_tri_valid;
      out_tri_a_r     <= res_tri_a;
      out_tri_b_r     <= res_tri_b;
      out_tri_c_r     <= res_tri_c;
      out_total_r     <= next_idx_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_index = out_mapped_r;
  assign out_present      = out_present_r;
  assign out_first_use    = out_first_use_r;
  assign out_tri_valid    = out_tri_valid_r;
  assign out_tri_a        = out_tri_a_r;
  assign out_tri_b        = out_tri_b_r;
  assign out_tri_c        = out_tri_c_r;
  assign out_vertex_total = out_total_r;

`ifndef SYNTH
  // The live epoch is never the tag that marks a cleared entry
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != EPOCH_NONE)
    else $error("epoch reached the cleared tag");

  // A first use bumps the dense index counter by exactly one
  a_first_use_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !sweep_r && item_we) |=> (next_idx_r == $past(next_idx_r) + CNT_W'(1)))
    else $error("dense index counter did not advance on first use");

  // No word sits in stage 1 while the sweep owns the map
  a_sweep_empty: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r |-> !s1_valid_r)
    else $error("word in flight during clearing sweep");

  // A result marked first use is always a present corner
  a_first_use_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_first_use_r) |-> (out_present_r && (out_total_r != '0)))
    else $error("first use without a present mapped corner");
`endif

endmodule
